// ===== src/transparent_column_post_encoder_assert.svh =====
// Assertion macros for the post encoder module.
`ifndef TRANSPARENT_COLUMN_POST_ENCODER_ASSERT_SVH
`define TRANSPARENT_COLUMN_POST_ENCODER_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define TCPE_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tcpe: invariant violated");

// Checks that a consequence holds in the same cycle as its trigger.
`define TCPE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcpe: implication violated");

`endif

// ===== src/tcpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpe_pkg
// Types and constants shared by the transparent column post encoder.
// ----------------------------------------------------------------------------
package tcpe_pkg;

  localparam int unsigned HEIGHT_W     = 15;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned CFG_DATA_W   = 15;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned RESULT_SLOTS = 5;
  localparam int unsigned COUNT_W      = $clog2(RESULT_SLOTS + 1);
  localparam int unsigned SLOT_W       = $clog2(RESULT_SLOTS);

  localparam logic [PIX_W-1:0] TALL_MARK = 8'd254;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 15'd128;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_ENABLE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_VALUE    = 2'd2;

  typedef enum logic [1:0] {
    KIND_PIXEL      = 2'd0,
    KIND_POST       = 2'd1,
    KIND_COLUMN_END = 2'd2
  } kind_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] image_height;
    logic                key_enable;
    logic [PIX_W-1:0]    key_value;
  } cfg_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] row_count;
    logic [PIX_W-1:0]    run_offset;
    logic                post_open;
    logic                past_tall_marker;
    logic [PIX_W-1:0]    post_start;
    logic [PIX_W-1:0]    post_count;
    logic [PIX_W-1:0]    first_pixel;
    logic [PIX_W-1:0]    last_pixel;
  } col_state_t;

  typedef struct packed {
    kind_t            kind;
    logic [PIX_W-1:0] pixel_value;
    logic [PIX_W-1:0] post_offset;
    logic [PIX_W-1:0] post_length;
    logic [PIX_W-1:0] pad_first;
    logic [PIX_W-1:0] pad_last;
    logic             last_of_run;
  } result_t;

endpackage

// ===== src/tcpe_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpe_step
// Combinational update for one pixel: next column state and the ordered
// list of results that the pixel causes.
// ----------------------------------------------------------------------------
module tcpe_step (
  input  logic [tcpe_pkg::PIX_W-1:0]   pixel,
  input  tcpe_pkg::cfg_t               cfg,
  input  tcpe_pkg::col_state_t         cur,
  output tcpe_pkg::col_state_t         nxt,
  output tcpe_pkg::result_t            slots [tcpe_pkg::RESULT_SLOTS],
  output logic [tcpe_pkg::COUNT_W-1:0] count
);

  function automatic tcpe_pkg::result_t make_result(
    input tcpe_pkg::kind_t            k,
    input logic [tcpe_pkg::PIX_W-1:0] pix,
    input logic [tcpe_pkg::PIX_W-1:0] off,
    input logic [tcpe_pkg::PIX_W-1:0] len,
    input logic [tcpe_pkg::PIX_W-1:0] pf,
    input logic [tcpe_pkg::PIX_W-1:0] pl
  );
    tcpe_pkg::result_t r;
    r.kind        = k;
    r.pixel_value = pix;
    r.post_offset = off;
    r.post_length = len;
    r.pad_first   = pf;
    r.pad_last    = pl;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    tcpe_pkg::result_t             cand [tcpe_pkg::RESULT_SLOTS];
    logic [tcpe_pkg::RESULT_SLOTS-1:0] cand_valid;
    tcpe_pkg::col_state_t          s;
    logic                          marker;
    logic                          opaque;
    logic                          column_end;
    logic [tcpe_pkg::HEIGHT_W-1:0] rows;
    logic [tcpe_pkg::COUNT_W-1:0]  n;

    s      = cur;
    marker = (cur.run_offset == tcpe_pkg::TALL_MARK);
    opaque = !cfg.key_enable || (pixel != cfg.key_value);

    cand[0] = make_result(tcpe_pkg::KIND_POST, '0, cur.post_start, cur.post_count,
                          cur.first_pixel, cur.last_pixel);
    cand_valid[0] = marker && cur.post_open;
    cand[1] = make_result(tcpe_pkg::KIND_POST, '0, tcpe_pkg::TALL_MARK, '0, '0, '0);
    cand_valid[1] = marker;
    if (marker) begin
      s.post_open        = 1'b0;
      s.past_tall_marker = 1'b1;
      s.run_offset       = '0;
      if (cur.post_open) begin
        s.post_count = '0;
      end
    end

    if (opaque) begin
      cand[2]       = make_result(tcpe_pkg::KIND_PIXEL, pixel, '0, '0, '0, '0);
      cand_valid[2] = 1'b1;
      if (!s.post_open) begin
        s.post_start  = s.run_offset;
        if (s.past_tall_marker) begin
          s.run_offset = '0;
        end
        s.post_open   = 1'b1;
        s.post_count  = '0;
        s.first_pixel = pixel;
      end
      s.post_count = s.post_count + 8'd1;
      s.last_pixel = pixel;
    end else begin
      cand[2] = make_result(tcpe_pkg::KIND_POST, '0, s.post_start, s.post_count,
                            s.first_pixel, s.last_pixel);
      cand_valid[2] = s.post_open;
      s.post_open   = 1'b0;
      if (s.post_open != cand_valid[2]) begin
        s.post_count = '0;
      end
    end

    s.run_offset = s.run_offset + 8'd1;
    rows         = cur.row_count + 15'd1;
    s.row_count  = rows;
    column_end   = (rows >= cfg.image_height) || (rows == '0);

    cand[3] = make_result(tcpe_pkg::KIND_POST, '0, s.post_start, s.post_count,
                          s.first_pixel, s.last_pixel);
    cand_valid[3] = column_end && s.post_open;
    cand[4] = make_result(tcpe_pkg::KIND_COLUMN_END, '0, '0, '0, '0, '0);
    cand_valid[4] = column_end;
    if (column_end) begin
      s = '0;
    end

    for (int k = 0; k < tcpe_pkg::RESULT_SLOTS; k++) begin
      slots[k] = '0;
    end
    n = '0;
    for (int i = 0; i < tcpe_pkg::RESULT_SLOTS; i++) begin
      if (cand_valid[i]) begin
        slots[n[tcpe_pkg::SLOT_W-1:0]] = cand[i];
        n = n + tcpe_pkg::COUNT_W'(1);
      end
    end
    for (int k = 0; k < tcpe_pkg::RESULT_SLOTS; k++) begin
      slots[k].last_of_run = (tcpe_pkg::COUNT_W'(k) == (n - tcpe_pkg::COUNT_W'(1)));
    end

    nxt   = s;
    count = n;
  end

endmodule

// ===== src/transparent_column_post_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transparent_column_post_encoder
// Splits column-major palette pixels into posts of opaque pixels, echoing
// each opaque pixel and closing posts with offset, length and pad bytes.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    pixel
//   out      source     out_valid / out_ready  kind .. last_of_run
//   cfg      sink       cfg_write              cfg_index, cfg_data
//
// A pixel is held in the input register until the result slots are free, then
// the results it causes, none to five, are loaded into the result slots together.
// The result slots drain one transaction per cycle while out_ready is high, and
// a pixel's results are loaded as the last result of the one before is taken.
// Reset clears the column state and the slot count and returns the
// registers to their reset values.
// A stall on out holds the slots and, once the input register is full,
// stalls in as well.
// ----------------------------------------------------------------------------
`include "transparent_column_post_encoder_assert.svh"

module transparent_column_post_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tcpe_pkg::PIX_W-1:0]          pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          kind,
  output logic [tcpe_pkg::PIX_W-1:0]          pixel_value,
  output logic [tcpe_pkg::PIX_W-1:0]          post_offset,
  output logic [tcpe_pkg::PIX_W-1:0]          post_length,
  output logic [tcpe_pkg::PIX_W-1:0]          pad_first,
  output logic [tcpe_pkg::PIX_W-1:0]          pad_last,
  output logic                                last_of_run,
  input  logic                                cfg_write,
  input  logic [tcpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tcpe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tcpe_pkg::cfg_t               cfg;
  tcpe_pkg::col_state_t         col_state;
  tcpe_pkg::col_state_t         col_state_next;
  logic                         in_full;
  logic [tcpe_pkg::PIX_W-1:0]   pixel_reg;
  tcpe_pkg::result_t            slots [tcpe_pkg::RESULT_SLOTS];
  tcpe_pkg::result_t            slots_next [tcpe_pkg::RESULT_SLOTS];
  logic [tcpe_pkg::COUNT_W-1:0] count;
  logic [tcpe_pkg::COUNT_W-1:0] count_next;
  logic                         slots_free;
  logic                         process;
  logic                         out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_height <= tcpe_pkg::HEIGHT_RESET;
      cfg.key_enable   <= 1'b0;
      cfg.key_value    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tcpe_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        tcpe_pkg::REG_KEY_ENABLE:   cfg.key_enable   <= cfg_data[0];
        tcpe_pkg::REG_KEY_VALUE:    cfg.key_value    <= cfg_data[tcpe_pkg::PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_take   = out_valid && out_ready;
  assign slots_free = (count == '0) || ((count == tcpe_pkg::COUNT_W'(1)) && out_ready);
  assign process    = in_full && slots_free;
  assign in_ready   = !in_full || process;
  assign out_valid  = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pixel_reg <= pixel;
    end
  end

  tcpe_step u_step (
    .pixel (pixel_reg),
    .cfg   (cfg),
    .cur   (col_state),
    .nxt   (col_state_next),
    .slots (slots_next),
    .count (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_state <= '0;
    end else if (process) begin
      col_state <= col_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (process) begin
      count <= count_next;
    end else if (out_take) begin
      count <= count - tcpe_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      slots <= slots_next;
    end else if (out_take) begin
      for (int k = 0; k < tcpe_pkg::RESULT_SLOTS - 1; k++) begin
        slots[k] <= slots[k+1];
      end
    end
  end

  assign kind        = slots[0].kind;
  assign pixel_value = slots[0].pixel_value;
  assign post_offset = slots[0].post_offset;
  assign post_length = slots[0].post_length;
  assign pad_first   = slots[0].pad_first;
  assign pad_last    = slots[0].pad_last;
  assign last_of_run = slots[0].last_of_run;

  `TCPE_ASSERT_ALWAYS(a_count_bound, count <= tcpe_pkg::COUNT_W'(tcpe_pkg::RESULT_SLOTS))
  `TCPE_ASSERT_ALWAYS(a_offset_bound, col_state.run_offset <= tcpe_pkg::TALL_MARK)
  `TCPE_ASSERT_IMPLIES(a_last_marks_end, out_valid, last_of_run == (count == tcpe_pkg::COUNT_W'(1)))
  `TCPE_ASSERT_IMPLIES(a_closed_post_empty, !col_state.post_open, col_state.post_count == '0)
  `TCPE_ASSERT_IMPLIES(a_stall_only_when_full, !in_ready, in_full && out_valid)

endmodule

// ===== test/post_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// post_stream_checker
// Watches the pixel, result and register ports of the post encoder. Each
// accepted pixel is run through a local copy of the column state to get the
// results it should cause, and every accepted result transaction is compared
// field by field with the oldest of those.
// ----------------------------------------------------------------------------
module post_stream_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [tcpe_pkg::PIX_W-1:0]       pixel,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [1:0]                       kind,
  input  logic [tcpe_pkg::PIX_W-1:0]       pixel_value,
  input  logic [tcpe_pkg::PIX_W-1:0]       post_offset,
  input  logic [tcpe_pkg::PIX_W-1:0]       post_length,
  input  logic [tcpe_pkg::PIX_W-1:0]       pad_first,
  input  logic [tcpe_pkg::PIX_W-1:0]       pad_last,
  input  logic                             last_of_run,
  input  logic                             cfg_write,
  input  logic [tcpe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcpe_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               pending
);

  tcpe_pkg::cfg_t       regs;
  tcpe_pkg::col_state_t col;
  tcpe_pkg::result_t    post_results_q[$];
  tcpe_pkg::result_t    burst_q[$];
  int                   miss_count = 0;
  int                   result_count = 0;

  assign mismatches = miss_count;

  task automatic report_mismatch(input string msg);
    $display("post_stream_checker: transaction %0d: %s", result_count, msg);
    miss_count++;
  endtask

  function automatic tcpe_pkg::result_t make_result(
    input tcpe_pkg::kind_t            k,
    input logic [tcpe_pkg::PIX_W-1:0] pv,
    input logic [tcpe_pkg::PIX_W-1:0] off,
    input logic [tcpe_pkg::PIX_W-1:0] len,
    input logic [tcpe_pkg::PIX_W-1:0] pf,
    input logic [tcpe_pkg::PIX_W-1:0] pl
  );
    tcpe_pkg::result_t r;
    r.kind        = k;
    r.pixel_value = pv;
    r.post_offset = off;
    r.post_length = len;
    r.pad_first   = pf;
    r.pad_last    = pl;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic close_post();
    if (col.post_open) begin
      burst_q.push_back(make_result(tcpe_pkg::KIND_POST, '0, col.post_start, col.post_count,
                                    col.first_pixel, col.last_pixel));
      col.post_open  = 1'b0;
      col.post_count = '0;
    end
  endtask

  task automatic encode_pixel(input logic [tcpe_pkg::PIX_W-1:0] pix);
    logic              opaque;
    int                last_idx;
    tcpe_pkg::result_t r;
    burst_q.delete();
    opaque = !regs.key_enable || (pix != regs.key_value);
    if (col.run_offset == tcpe_pkg::TALL_MARK) begin
      close_post();
      col.past_tall_marker = 1'b1;
      burst_q.push_back(make_result(tcpe_pkg::KIND_POST, '0, tcpe_pkg::TALL_MARK,
                                    '0, '0, '0));
      col.run_offset = '0;
    end
    if (opaque) begin
      if (!col.post_open) begin
        col.post_start = col.run_offset;
        if (col.past_tall_marker) begin
          col.run_offset = '0;
        end
        col.post_open   = 1'b1;
        col.post_count  = '0;
        col.first_pixel = pix;
      end
      col.post_count = col.post_count + 1'b1;
      col.last_pixel = pix;
      burst_q.push_back(make_result(tcpe_pkg::KIND_PIXEL, pix, '0, '0, '0, '0));
    end else begin
      close_post();
    end
    col.run_offset = col.run_offset + 1'b1;
    col.row_count  = col.row_count + 1'b1;
    if (col.row_count >= regs.image_height || col.row_count == '0) begin
      close_post();
      burst_q.push_back(make_result(tcpe_pkg::KIND_COLUMN_END, '0, '0, '0, '0, '0));
      col = '0;
    end
    last_idx = burst_q.size() - 1;
    foreach (burst_q[i]) begin
      r = burst_q[i];
      r.last_of_run = (i == last_idx);
      post_results_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [tcpe_pkg::PIX_W-1:0] got,
                             input logic [tcpe_pkg::PIX_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic check_result();
    tcpe_pkg::result_t want;
    if (post_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction of kind %0d", kind));
    end else begin
      want = post_results_q.pop_front();
      check_field("kind", {6'b0, kind}, {6'b0, want.kind});
      check_field("pixel_value", pixel_value, want.pixel_value);
      check_field("post_offset", post_offset, want.post_offset);
      check_field("post_length", post_length, want.post_length);
      check_field("pad_first", pad_first, want.pad_first);
      check_field("pad_last", pad_last, want.pad_last);
      check_field("last_of_run", {7'b0, last_of_run}, {7'b0, want.last_of_run});
    end
    result_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.image_height = tcpe_pkg::HEIGHT_RESET;
      regs.key_enable   = 1'b0;
      regs.key_value    = '0;
      col               = '0;
      post_results_q.delete();
    end else begin
      // A result accepted now comes from an earlier pixel, so it is checked
      // before this edge's pixel adds its own results.
      if (out_valid && out_ready) begin
        check_result();
      end
      if (cfg_write) begin
        case (cfg_index)
          tcpe_pkg::REG_IMAGE_HEIGHT: regs.image_height = cfg_data[tcpe_pkg::HEIGHT_W-1:0];
          tcpe_pkg::REG_KEY_ENABLE:   regs.key_enable   = cfg_data[0];
          tcpe_pkg::REG_KEY_VALUE:    regs.key_value    = cfg_data[tcpe_pkg::PIX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        encode_pixel(pixel);
      end
    end
    pending <= post_results_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the post encoder with directed and random pixel columns under
// several register settings, including tall columns that cross the row 254
// marker, with random stalls on both channels. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT_CYCLES = 200000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [tcpe_pkg::PIX_W-1:0]       pixel = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [1:0]                       kind;
  logic [tcpe_pkg::PIX_W-1:0]       pixel_value;
  logic [tcpe_pkg::PIX_W-1:0]       post_offset;
  logic [tcpe_pkg::PIX_W-1:0]       post_length;
  logic [tcpe_pkg::PIX_W-1:0]       pad_first;
  logic [tcpe_pkg::PIX_W-1:0]       pad_last;
  logic                             last_of_run;
  logic                             cfg_write = 1'b0;
  logic [tcpe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tcpe_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int                               mismatches;
  int                               pending;
  int                               cycle_count = 0;
  logic                             calm = 1'b0;
  logic                             key_on = 1'b0;
  logic [tcpe_pkg::PIX_W-1:0]       key_val = '0;

  transparent_column_post_encoder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .pixel_value(pixel_value), .post_offset(post_offset),
    .post_length(post_length), .pad_first(pad_first), .pad_last(pad_last),
    .last_of_run(last_of_run),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  post_stream_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .pixel_value(pixel_value), .post_offset(post_offset),
    .post_length(post_length), .pad_first(pad_first), .pad_last(pad_last),
    .last_of_run(last_of_run),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_pixel(input logic [tcpe_pkg::PIX_W-1:0] p);
    if (!calm) begin
      while ($urandom_range(99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    pixel    <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Transparent pixels leave nothing to wait for, so a fixed pause follows.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic program_regs(input logic [tcpe_pkg::HEIGHT_W-1:0] height, input logic ke,
                              input logic [tcpe_pkg::PIX_W-1:0] kv);
    cfg_write <= 1'b1;
    cfg_index <= tcpe_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= height;
    @(posedge clk);
    cfg_index <= tcpe_pkg::REG_KEY_ENABLE;
    cfg_data  <= {{(tcpe_pkg::CFG_DATA_W-1){1'b0}}, ke};
    @(posedge clk);
    cfg_index <= tcpe_pkg::REG_KEY_VALUE;
    cfg_data  <= {{(tcpe_pkg::CFG_DATA_W-tcpe_pkg::PIX_W){1'b0}}, kv};
    @(posedge clk);
    cfg_write <= 1'b0;
    key_on  = ke;
    key_val = kv;
  endtask

  function automatic logic [tcpe_pkg::PIX_W-1:0] pick_pixel(input bit want_key);
    logic [tcpe_pkg::PIX_W-1:0] p;
    if (want_key) begin
      return key_val;
    end
    p = 8'($urandom_range(255));
    while (key_on && p == key_val) p = 8'($urandom_range(255));
    return p;
  endfunction

  // Pixels before opaque_rows are never the key, so a tall column can fill
  // a single post up to the row 254 marker.
  task automatic run_phase(input int count, input int key_pct, input int opaque_rows);
    for (int i = 0; i < count; i++) begin
      send_pixel(pick_pixel(i >= opaque_rows && $urandom_range(99) < key_pct));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: key disabled, height 128.
    send_pixel(8'h00);
    send_pixel(8'hff);
    send_pixel(8'h55);
    send_pixel(8'haa);
    wait_idle();

    // Height zero ends a column at every pixel.
    program_regs('0, 1'b1, 8'h00);
    send_pixel(8'h00);
    send_pixel(8'hff);
    wait_idle();

    program_regs(15'h7fff, 1'b1, 8'hff);
    send_pixel(8'hff);
    send_pixel(8'hff);
    send_pixel(8'h01);
    send_pixel(8'h02);
    send_pixel(8'hff);
    send_pixel(8'h00);
    wait_idle();

    // Height lowered below the rows already taken in this column.
    program_regs(15'd3, 1'b1, 8'hff);
    send_pixel(8'h07);
    send_pixel(8'hff);
    send_pixel(8'h09);
    send_pixel(8'h09);
    wait_idle();

    program_regs(15'd7, 1'b1, 8'($urandom_range(255)));
    run_phase(14, 35, 0);
    wait_idle();

    program_regs(15'd1, 1'b1, 8'($urandom_range(255)));
    run_phase(10, 40, 0);
    wait_idle();

    program_regs(15'd300, 1'b1, 8'($urandom_range(255)));
    run_phase(260, 40, 254);
    wait_idle();

    calm <= 1'b1;
    program_regs(15'd20, 1'b0, 8'($urandom_range(255)));
    run_phase(30, 40, 0);
    wait_idle();
    calm <= 1'b0;

    program_regs(15'd2, 1'b1, 8'h00);
    run_phase(12, 40, 0);
    wait_idle();
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== transparent_column_post_encoder.f =====
+incdir+src
src/tcpe_pkg.sv
src/tcpe_step.sv
src/transparent_column_post_encoder.sv
test/post_stream_checker.sv
test/tb_top.sv
